// ===== design/netpbm_stream_decoder_unit_assert.svh =====
// Assertion macros used by the decoder controller.
`ifndef NETPBM_STREAM_DECODER_UNIT_ASSERT_SVH
`define NETPBM_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/nsd_pkg.sv =====
// Shared types and constants of the Netpbm stream decoder.
package nsd_pkg;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_MAGIC  = 3'd1;
	localparam logic [2:0] ERR_NUMBER = 3'd2;
	localparam logic [2:0] ERR_MAXVAL = 3'd3;
	localparam logic [2:0] ERR_EARLY  = 3'd4;

	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_CLR   = 2'd1;
	localparam logic [1:0] ACC_DIGIT = 2'd2;

	localparam logic [1:0] SRC_ACC  = 2'd0;
	localparam logic [1:0] SRC_BYTE = 2'd1;
	localparam logic [1:0] SRC_WORD = 2'd2;

	localparam logic [1:0] PIX_GRAY  = 2'd0;
	localparam logic [1:0] PIX_RGB   = 2'd1;
	localparam logic [1:0] PIX_CONST = 2'd2;

	localparam int         ACC_W    = 17;
	localparam logic [16:0] ACC_MAX = 17'd131071;
	localparam logic [3:0] DIV_STEPS = 4'd9;

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_6    = 8'h36;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;

	typedef struct packed {
		logic       cap_byte;
		logic [1:0] acc_op;
		logic       ld_w;
		logic       ld_h;
		logic       ld_max;
		logic       max_one;
		logic       div_start;
		logic [1:0] div_src;
		logic       start_img;
		logic       p4_col;
		logic       pix_dec;
		logic       ld_red;
		logic       ld_green;
		logic       ld_high;
		logic       out_load;
		logic [1:0] out_kind;
		logic [1:0] pix_src;
		logic       pix_const;
		logic [2:0] out_err;
		logic       out_last_run;
		logic [2:0] out_fmt;
		logic       clr_all;
	} nsd_cmd_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       acc_gt_dim;
		logic       acc_zero;
		logic       acc_gt_max16;
		logic       max_lt256;
		logic       wh_zero;
		logic       pix_one;
		logic       pix_zero;
		logic       pix_gt8;
		logic [3:0] p4_cnt;
		logic       div_done;
		logic       out_free;
	} nsd_sts_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [2:0]  format_type;
		logic [2:0]  error_code;
		logic        last_of_run;
		logic        last_of_image;
	} nsd_result_t;

endpackage

// ===== design/nsd_byte_if.sv =====
// Input byte channel.
interface nsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source(output valid, output data_byte, output end_of_stream, input ready);
	modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== design/nsd_result_if.sv =====
// Output result channel.
interface nsd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic [2:0]  format_type;
	logic [2:0]  error_code;
	logic        last_of_run;
	logic        last_of_image;

	modport source(output valid, output result_kind, output red, output green, output blue,
		output image_width, output image_height, output format_type, output error_code,
		output last_of_run, output last_of_image, input ready);
	modport sink(input valid, input result_kind, input red, input green, input blue,
		input image_width, input image_height, input format_type, input error_code,
		input last_of_run, input last_of_image, output ready);
endinterface

// ===== design/nsd_datapath.sv =====
// Datapath: header registers, pixel counters, scaling divider and output register.
module nsd_datapath #(
	parameter int MAX_DIM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  nsd_pkg::nsd_cmd_t  cmd,
	output nsd_pkg::nsd_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output nsd_pkg::nsd_result_t res
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int PIX_W = 2 * DIM_W;

	logic [7:0]       byte_q;
	logic [16:0]      acc_q;
	logic [DIM_W-1:0] w_q, h_q, col_q;
	logic [15:0]      max_q;
	logic [PIX_W-1:0] pix_q;
	logic [7:0]       high_q, red_q, green_q;
	logic [24:0]      rem_q;
	logic [23:0]      div_q;
	logic [8:0]       quo_q;
	logic [3:0]       dcnt_q;
	logic             busy_q;
	logic             out_valid_q;
	nsd_pkg::nsd_result_t res_q;

	logic [20:0]      acc_mul;
	logic [16:0]      acc_next;
	logic [DIM_W-1:0] left;
	logic [DIM_W+3:0] left_x, col_x;
	logic             left_le8;
	logic [PIX_W-1:0] area;
	logic [16:0]      dsrc;
	logic [24:0]      dnum;
	logic             ge;
	logic [7:0]       q8;
	logic [7:0]       pr, pg, pb, cval;

	// Accumulate one decimal digit, saturating.
	always_comb begin
		acc_mul  = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {17'd0, byte_q[3:0]};
		acc_next = (acc_mul > 21'(nsd_pkg::ACC_MAX)) ? nsd_pkg::ACC_MAX : acc_mul[16:0];
	end

	always_comb begin
		left     = (w_q > col_q) ? w_q - col_q : '0;
		left_x   = (DIM_W + 4)'(left);
		col_x    = (DIM_W + 4)'(col_q) + (DIM_W + 4)'(8);
		left_le8 = left_x <= (DIM_W + 4)'(8);
		area     = PIX_W'(w_q) * PIX_W'(h_q);
	end

	// Scale numerator: value * 255.
	always_comb begin
		unique case (cmd.div_src)
			nsd_pkg::SRC_BYTE: dsrc = {9'd0, byte_q};
			nsd_pkg::SRC_WORD: dsrc = {1'b0, high_q, byte_q};
			default:           dsrc = acc_q;
		endcase
		dnum = {dsrc, 8'd0} - {8'd0, dsrc};
		ge   = rem_q >= {1'b0, div_q};
		q8   = quo_q[8] ? 8'hFF : quo_q[7:0];
	end

	always_comb begin
		cval = cmd.pix_const ? 8'hFF : 8'h00;
		unique case (cmd.pix_src)
			nsd_pkg::PIX_RGB:   begin pr = red_q; pg = green_q; pb = q8; end
			nsd_pkg::PIX_CONST: begin pr = cval; pg = cval; pb = cval; end
			default:            begin pr = q8; pg = q8; pb = q8; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q  <= '0;
			acc_q   <= '0;
			w_q     <= '0;
			h_q     <= '0;
			max_q   <= '0;
			pix_q   <= '0;
			col_q   <= '0;
			high_q  <= '0;
			red_q   <= '0;
			green_q <= '0;
		end else begin
			if (cmd.cap_byte) byte_q <= data_byte;
			unique case (cmd.acc_op)
				nsd_pkg::ACC_CLR:   acc_q <= '0;
				nsd_pkg::ACC_DIGIT: acc_q <= acc_next;
				default: begin
				end
			endcase
			if (cmd.ld_w) w_q <= acc_q[DIM_W-1:0];
			if (cmd.ld_h) h_q <= acc_q[DIM_W-1:0];
			if (cmd.max_one) max_q <= 16'd1;
			else if (cmd.ld_max) max_q <= acc_q[15:0];
			if (cmd.start_img) begin
				pix_q <= area;
				col_q <= '0;
			end else begin
				if (cmd.pix_dec) pix_q <= pix_q - PIX_W'(1);
				if (cmd.p4_col) col_q <= left_le8 ? '0 : DIM_W'(col_x);
			end
			if (cmd.ld_high) high_q <= byte_q;
			if (cmd.ld_red) red_q <= q8;
			if (cmd.ld_green) green_q <= q8;
			if (cmd.clr_all) begin
				acc_q   <= '0;
				w_q     <= '0;
				h_q     <= '0;
				max_q   <= '0;
				pix_q   <= '0;
				col_q   <= '0;
				high_q  <= '0;
				red_q   <= '0;
				green_q <= '0;
			end
		end
	end

	// Restoring divider: one quotient bit per cycle, nine bits, top bit saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			busy_q <= 1'b1;
			dcnt_q <= nsd_pkg::DIV_STEPS;
		end else if (busy_q) begin
			dcnt_q <= dcnt_q - 4'd1;
			busy_q <= dcnt_q != 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= dnum;
			div_q <= {max_q, 8'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - {1'b0, div_q};
			quo_q <= {quo_q[7:0], ge};
			div_q <= div_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.result_kind   <= cmd.out_kind;
			res_q.red           <= (cmd.out_kind == nsd_pkg::KIND_PIXEL) ? pr : 8'd0;
			res_q.green         <= (cmd.out_kind == nsd_pkg::KIND_PIXEL) ? pg : 8'd0;
			res_q.blue          <= (cmd.out_kind == nsd_pkg::KIND_PIXEL) ? pb : 8'd0;
			res_q.image_width   <= (cmd.out_kind == nsd_pkg::KIND_HEADER) ? 13'(w_q) : 13'd0;
			res_q.image_height  <= (cmd.out_kind == nsd_pkg::KIND_HEADER) ? 13'(h_q) : 13'd0;
			res_q.format_type   <= cmd.out_fmt;
			res_q.error_code    <= cmd.out_err;
			res_q.last_of_run   <= cmd.out_last_run;
			res_q.last_of_image <= (cmd.out_kind == nsd_pkg::KIND_PIXEL) &&
				(pix_q == PIX_W'(1));
		end
	end

	always_comb begin
		sts.byte_val     = byte_q;
		sts.acc_gt_dim   = acc_q > 17'(MAX_DIM);
		sts.acc_zero     = acc_q == '0;
		sts.acc_gt_max16 = acc_q[16];
		sts.max_lt256    = max_q[15:8] == 8'd0;
		sts.wh_zero      = (w_q == '0) || (h_q == '0);
		sts.pix_one      = pix_q == PIX_W'(1);
		sts.pix_zero     = pix_q == '0;
		sts.pix_gt8      = pix_q > PIX_W'(8);
		sts.p4_cnt       = left_le8 ? 4'(left_x) : 4'd8;
		sts.div_done     = !busy_q;
		sts.out_free     = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ===== design/nsd_ctrl.sv =====
// Controller: parse phase tracking and per-item sequencing of the datapath.
`include "netpbm_stream_decoder_unit_assert.svh"
module nsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              end_of_stream,
	output logic              in_ready,
	output nsd_pkg::nsd_cmd_t cmd,
	input  nsd_pkg::nsd_sts_t sts
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_FIN   = 4'd2;
	localparam logic [3:0] ST_HDR   = 4'd3;
	localparam logic [3:0] ST_ERR   = 4'd4;
	localparam logic [3:0] ST_DIVGO = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_SMP   = 4'd7;
	localparam logic [3:0] ST_PIX   = 4'd8;
	localparam logic [3:0] ST_P4    = 4'd9;
	localparam logic [3:0] ST_TAIL  = 4'd10;

	localparam logic [3:0] PH_MAGIC  = 4'd0;
	localparam logic [3:0] PH_DIGIT  = 4'd1;
	localparam logic [3:0] PH_WIDTH  = 4'd2;
	localparam logic [3:0] PH_HEIGHT = 4'd3;
	localparam logic [3:0] PH_MAXVAL = 4'd4;
	localparam logic [3:0] PH_ASCII  = 4'd5;
	localparam logic [3:0] PH_BINARY = 4'd6;
	localparam logic [3:0] PH_DONE   = 4'd7;
	localparam logic [3:0] PH_ERROR  = 4'd8;

	logic [3:0] state_q, state_d, phase_q, phase_d;
	logic [2:0] fmt_q, fmt_d, err_q, err_d, p4idx_q, p4idx_d;
	logic       comment_q, comment_d, digits_q, digits_d, bp_q, bp_d;
	logic       eos_q, eos_d, hash_q, hash_d, const_q, const_d;
	logic [1:0] ch_q, ch_d, src_q, src_d;
	logic [3:0] p4cnt_q, p4cnt_d, cnt8;

	logic [7:0] b;
	logic       is_digit, is_ws, is_eol, is_hash, is_mdig, fmt_bin, fmt_rgb, fmt_mono1;
	logic       more;

	always_comb begin
		b         = sts.byte_val;
		is_digit  = (b >= nsd_pkg::CH_0) && (b <= nsd_pkg::CH_9);
		is_eol    = (b == nsd_pkg::CH_LF) || (b == nsd_pkg::CH_CR);
		is_ws     = (b == nsd_pkg::CH_SP) || (b == nsd_pkg::CH_TAB) || (b == nsd_pkg::CH_LF) ||
			(b == nsd_pkg::CH_VT) || (b == nsd_pkg::CH_FF) || (b == nsd_pkg::CH_CR);
		is_hash   = b == nsd_pkg::CH_HASH;
		is_mdig   = (b >= nsd_pkg::CH_1) && (b <= nsd_pkg::CH_6);
		fmt_bin   = fmt_q >= 3'd4;
		fmt_rgb   = (fmt_q == 3'd3) || (fmt_q == 3'd6);
		fmt_mono1 = (fmt_q == 3'd1) || (fmt_q == 3'd4);
		cnt8      = (eos_q && (sts.p4_cnt == 4'd8) && sts.pix_gt8) ? 4'd7 : sts.p4_cnt;
		more      = p4cnt_q != 4'd1;
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		fmt_d     = fmt_q;
		err_d     = err_q;
		comment_d = comment_q;
		digits_d  = digits_q;
		bp_d      = bp_q;
		eos_d     = eos_q;
		hash_d    = hash_q;
		const_d   = const_q;
		ch_d      = ch_q;
		src_d     = src_q;
		p4cnt_d   = p4cnt_q;
		p4idx_d   = p4idx_q;
		cmd       = '0;
		cmd.out_fmt = fmt_q;
		in_ready  = state_q == ST_IDLE;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_byte = 1'b1;
					eos_d        = end_of_stream;
					state_d      = ST_DEC;
				end
			end
			ST_DEC: begin
				state_d = ST_TAIL;
				unique case (phase_q)
					PH_MAGIC: begin
						if (comment_q) begin
							if (is_eol) comment_d = 1'b0;
						end else if (is_ws) begin
						end else if (is_hash) comment_d = 1'b1;
						else if (b == nsd_pkg::CH_P) phase_d = PH_DIGIT;
						else begin
							err_d   = nsd_pkg::ERR_MAGIC;
							state_d = ST_ERR;
						end
					end
					PH_DIGIT: begin
						if (is_mdig) begin
							fmt_d   = b[2:0];
							phase_d = PH_WIDTH;
						end else begin
							err_d   = nsd_pkg::ERR_MAGIC;
							state_d = ST_ERR;
						end
					end
					PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
						if (comment_q) begin
							if (is_eol) comment_d = 1'b0;
						end else if (is_digit) begin
							cmd.acc_op = nsd_pkg::ACC_DIGIT;
							digits_d   = 1'b1;
							if (eos_q) begin
								hash_d  = 1'b0;
								state_d = ST_FIN;
							end
						end else if (is_ws || is_hash) begin
							if (digits_q) begin
								hash_d  = is_hash;
								state_d = ST_FIN;
							end else if (is_hash) comment_d = 1'b1;
						end else begin
							err_d   = nsd_pkg::ERR_NUMBER;
							state_d = ST_ERR;
						end
					end
					PH_ASCII: begin
						if (comment_q) begin
							if (is_eol) comment_d = 1'b0;
						end else if (fmt_q == 3'd1) begin
							if (is_hash) comment_d = 1'b1;
							else if (b == nsd_pkg::CH_0) begin
								const_d = 1'b1;
								state_d = ST_PIX;
							end else if (b == nsd_pkg::CH_1) begin
								const_d = 1'b0;
								state_d = ST_PIX;
							end
						end else if (is_digit) begin
							cmd.acc_op = nsd_pkg::ACC_DIGIT;
							digits_d   = 1'b1;
							if (eos_q) begin
								src_d   = nsd_pkg::SRC_ACC;
								state_d = ST_DIVGO;
							end
						end else if (is_ws || is_hash) begin
							if (digits_q) begin
								src_d   = nsd_pkg::SRC_ACC;
								state_d = ST_DIVGO;
							end
							if (is_hash) comment_d = 1'b1;
						end else begin
							err_d   = nsd_pkg::ERR_NUMBER;
							state_d = ST_ERR;
						end
					end
					PH_BINARY: begin
						if (fmt_q == 3'd4) begin
							cmd.p4_col = 1'b1;
							p4cnt_d    = cnt8;
							p4idx_d    = 3'd0;
							if (cnt8 != 4'd0) state_d = ST_P4;
						end else if (sts.max_lt256) begin
							src_d   = nsd_pkg::SRC_BYTE;
							state_d = ST_DIVGO;
						end else if (!bp_q) begin
							cmd.ld_high = 1'b1;
							bp_d        = 1'b1;
						end else begin
							bp_d    = 1'b0;
							src_d   = nsd_pkg::SRC_WORD;
							state_d = ST_DIVGO;
						end
					end
					default: begin
					end
				endcase
			end
			ST_FIN: begin
				cmd.acc_op = nsd_pkg::ACC_CLR;
				digits_d   = 1'b0;
				state_d    = ST_TAIL;
				if (phase_q == PH_WIDTH || phase_q == PH_HEIGHT) begin
					if (sts.acc_gt_dim) begin
						err_d   = nsd_pkg::ERR_NUMBER;
						state_d = ST_ERR;
					end else if (phase_q == PH_WIDTH) begin
						cmd.ld_w = 1'b1;
						phase_d  = PH_HEIGHT;
						if (hash_q) comment_d = 1'b1;
					end else begin
						cmd.ld_h = 1'b1;
						if (!fmt_mono1) begin
							phase_d = PH_MAXVAL;
							if (hash_q) comment_d = 1'b1;
						end else begin
							cmd.max_one = 1'b1;
							if (hash_q && fmt_bin) begin
								err_d   = nsd_pkg::ERR_NUMBER;
								state_d = ST_ERR;
							end else begin
								if (hash_q) comment_d = 1'b1;
								state_d = ST_HDR;
							end
						end
					end
				end else begin
					if (sts.acc_zero || sts.acc_gt_max16) begin
						err_d   = nsd_pkg::ERR_MAXVAL;
						state_d = ST_ERR;
					end else begin
						cmd.ld_max = 1'b1;
						if (hash_q && fmt_bin) begin
							err_d   = nsd_pkg::ERR_NUMBER;
							state_d = ST_ERR;
						end else begin
							if (hash_q) comment_d = 1'b1;
							state_d = ST_HDR;
						end
					end
				end
			end
			ST_HDR: begin
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_kind     = nsd_pkg::KIND_HEADER;
					cmd.out_last_run = !(eos_q && !sts.wh_zero);
					cmd.start_img    = 1'b1;
					cmd.acc_op       = nsd_pkg::ACC_CLR;
					digits_d         = 1'b0;
					ch_d             = 2'd0;
					bp_d             = 1'b0;
					if (sts.wh_zero) phase_d = PH_DONE;
					else phase_d = fmt_bin ? PH_BINARY : PH_ASCII;
					state_d = ST_TAIL;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_kind     = nsd_pkg::KIND_ERROR;
					cmd.out_err      = err_q;
					cmd.out_last_run = 1'b1;
					phase_d          = PH_ERROR;
					state_d          = ST_TAIL;
				end
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = src_q;
				if (src_q == nsd_pkg::SRC_ACC) begin
					cmd.acc_op = nsd_pkg::ACC_CLR;
					digits_d   = 1'b0;
				end
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_SMP;
			end
			ST_SMP: begin
				if (fmt_rgb && ch_q == 2'd0) begin
					cmd.ld_red = 1'b1;
					ch_d       = 2'd1;
					state_d    = ST_TAIL;
				end else if (fmt_rgb && ch_q == 2'd1) begin
					cmd.ld_green = 1'b1;
					ch_d         = 2'd2;
					state_d      = ST_TAIL;
				end else if (sts.out_free || sts.pix_zero) begin
					ch_d    = 2'd0;
					state_d = ST_TAIL;
					if (!sts.pix_zero) begin
						cmd.out_load     = 1'b1;
						cmd.out_kind     = nsd_pkg::KIND_PIXEL;
						cmd.pix_src      = fmt_rgb ? nsd_pkg::PIX_RGB : nsd_pkg::PIX_GRAY;
						cmd.out_last_run = !(eos_q && !sts.pix_one);
						cmd.pix_dec      = 1'b1;
						if (sts.pix_one) phase_d = PH_DONE;
					end
				end
			end
			ST_PIX: begin
				if (sts.out_free || sts.pix_zero) begin
					state_d = ST_TAIL;
					if (!sts.pix_zero) begin
						cmd.out_load     = 1'b1;
						cmd.out_kind     = nsd_pkg::KIND_PIXEL;
						cmd.pix_src      = nsd_pkg::PIX_CONST;
						cmd.pix_const    = const_q;
						cmd.out_last_run = !(eos_q && !sts.pix_one);
						cmd.pix_dec      = 1'b1;
						if (sts.pix_one) phase_d = PH_DONE;
					end
				end
			end
			ST_P4: begin
				// Emit one packed bit per cycle while the output is free, MSB first; a set bit is black.
				if (sts.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_kind     = nsd_pkg::KIND_PIXEL;
					cmd.pix_src      = nsd_pkg::PIX_CONST;
					cmd.pix_const    = !b[~p4idx_q];
					cmd.out_last_run = !more && !(eos_q && !sts.pix_one);
					cmd.pix_dec      = 1'b1;
					if (sts.pix_one) phase_d = PH_DONE;
					p4idx_d = p4idx_q + 3'd1;
					p4cnt_d = p4cnt_q - 4'd1;
					if (!more) state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (!eos_q) state_d = ST_IDLE;
				else if (phase_q == PH_DONE || phase_q == PH_ERROR || sts.out_free) begin
					if (phase_q != PH_DONE && phase_q != PH_ERROR) begin
						cmd.out_load     = 1'b1;
						cmd.out_kind     = nsd_pkg::KIND_ERROR;
						cmd.out_err      = nsd_pkg::ERR_EARLY;
						cmd.out_last_run = 1'b1;
					end
					// Drop all file state so the next byte starts a new file.
					cmd.clr_all = 1'b1;
					phase_d     = PH_MAGIC;
					fmt_d       = 3'd0;
					comment_d   = 1'b0;
					digits_d    = 1'b0;
					ch_d        = 2'd0;
					bp_d        = 1'b0;
					eos_d       = 1'b0;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_MAGIC;
			fmt_q     <= '0;
			err_q     <= '0;
			comment_q <= 1'b0;
			digits_q  <= 1'b0;
			bp_q      <= 1'b0;
			eos_q     <= 1'b0;
			hash_q    <= 1'b0;
			const_q   <= 1'b0;
			ch_q      <= '0;
			src_q     <= '0;
			p4cnt_q   <= '0;
			p4idx_q   <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			fmt_q     <= fmt_d;
			err_q     <= err_d;
			comment_q <= comment_d;
			digits_q  <= digits_d;
			bp_q      <= bp_d;
			eos_q     <= eos_d;
			hash_q    <= hash_d;
			const_q   <= const_d;
			ch_q      <= ch_d;
			src_q     <= src_d;
			p4cnt_q   <= p4cnt_d;
			p4idx_q   <= p4idx_d;
		end
	end

	`NSD_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, sts.out_free, "load into busy output")
	`NSD_ASSERT_IMP(a_pix_avail, clk, arst_n, cmd.out_load && cmd.out_kind == nsd_pkg::KIND_PIXEL, !sts.pix_zero, "pixel past image end")
	`NSD_ASSERT_NXT(a_div_busy, clk, arst_n, cmd.div_start, !sts.div_done, "divider did not start")
	`NSD_ASSERT_NXT(a_eos_clear, clk, arst_n, cmd.clr_all, phase_q == PH_MAGIC && state_q == ST_IDLE, "stream end did not clear")

endmodule

// ===== design/netpbm_stream_decoder_unit.sv =====
// Sequencing: a byte is captured in IDLE, decoded in DEC and leaves through TAIL; one
// ending a header number also passes FIN, one completing the header FIN and HDR, a P1
// pixel byte PIX and an error byte ERR. A P2/P3/P5/P6 sample passes DIVGO, DIV (the
// 9-step restoring divider) and SMP. A P4 byte emits its pixels (up to 8) in P4, one
// output per cycle while the result channel is free. One byte is in work at a time.
// Reset (arst_n low, asynchronous) returns the parser to waiting for the magic number.
module netpbm_stream_decoder_unit #(
	parameter int MAX_DIM = 4096
) (
	input logic          clk,
	input logic          arst_n,
	nsd_byte_if.sink     byte_in,
	nsd_result_if.source result_out
);

	nsd_pkg::nsd_cmd_t    cmd;
	nsd_pkg::nsd_sts_t    sts;
	nsd_pkg::nsd_result_t res;
	logic                 in_ready;
	logic                 out_valid;

	nsd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (byte_in.valid),
		.end_of_stream (byte_in.end_of_stream),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.sts           (sts)
	);

	nsd_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_in.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (result_out.ready),
		.res       (res)
	);

	assign byte_in.ready            = in_ready;
	assign result_out.valid         = out_valid;
	assign result_out.result_kind   = res.result_kind;
	assign result_out.red           = res.red;
	assign result_out.green         = res.green;
	assign result_out.blue          = res.blue;
	assign result_out.image_width   = res.image_width;
	assign result_out.image_height  = res.image_height;
	assign result_out.format_type   = res.format_type;
	assign result_out.error_code    = res.error_code;
	assign result_out.last_of_run   = res.last_of_run;
	assign result_out.last_of_image = res.last_of_image;

endmodule
